// ----- sv/pstmr_pkg.sv -----
// ----------------------------------------------------------------------------
// pstmr_pkg
// Shared types, constants and helpers for the prescaled timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pstmr_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_WR_COUNTER   = 2'd1,
        OP_WR_CONTROL   = 2'd2
    } op_t;

    localparam int          DATA_W             = 8;
    localparam int          PRESCALE_W         = 10;
    localparam int          DELAY_W            = 3;
    localparam int          CTRL_ENABLE_BIT    = 2;
    localparam logic [DELAY_W-1:0] RELOAD_DELAY_TICKS = 3'd4;
    localparam logic [DATA_W-1:0]  COUNTER_MAX        = 8'hFF;

    // one input beat
    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [DATA_W-1:0] counter_value;
        logic              timer_interrupt;
    } result_t;

    // timer state visible to the top level for checking
    typedef struct packed {
        logic               enabled;
        logic [DELAY_W-1:0] reload_delay;
    } status_t;

    // prescaler period for each rate code
    function automatic logic [PRESCALE_W:0] period_of(input logic [1:0] rate);
        logic [PRESCALE_W:0] p;
        case (rate)
            2'd0:    p = 11'd1024;
            2'd1:    p = 11'd16;
            2'd2:    p = 11'd64;
            2'd3:    p = 11'd256;
            default: p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pstmr_in_stage.sv -----
// ----------------------------------------------------------------------------
// pstmr_in_stage
// Input register: holds one beat until the core can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module pstmr_in_stage
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // write_data[7:0]
    input  wire logic [1:0]                s_tuser,   // operation[1:0]
    input  wire logic                      take,      // core consumes the held beat
    output logic                           item_valid,
    output pstmr_pkg::item_t               item
);

    import pstmr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // accept when empty or when the held beat leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op   <= s_tuser;
            item_reg.data <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- sv/pstmr_core.sv -----
// ----------------------------------------------------------------------------
// pstmr_core
// Timer state and its update for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pstmr_core
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      reload_we,
    input  wire logic [7:0]                reload_data,
    input  wire logic                      fire,
    input  wire pstmr_pkg::item_t          item,
    output pstmr_pkg::result_t             result,
    output pstmr_pkg::status_t             status
);

    import pstmr_pkg::*;

    logic [DATA_W-1:0]     reload_reg;
    logic [DATA_W-1:0]     counter_reg,   counter_next;
    logic [PRESCALE_W-1:0] prescale_reg,  prescale_next;
    logic                  enabled_reg,   enabled_next;
    logic [1:0]            rate_reg,      rate_next;
    logic [DELAY_W-1:0]    delay_reg,     delay_next;
    logic                  irq;
    logic [PRESCALE_W:0]   pre_inc;

    assign pre_inc = {1'b0, prescale_reg} + 11'd1;

    // next state for the beat in the input register
    always_comb
    begin
        counter_next  = counter_reg;
        prescale_next = prescale_reg;
        enabled_next  = enabled_reg;
        rate_next     = rate_reg;
        delay_next    = delay_reg;
        irq           = 1'b0;
        case (op_t'(item.op))
            OP_TICK:
            begin
                // pending reload counts down first
                if (delay_reg != '0)
                begin
                    delay_next = delay_reg - 3'd1;
                    if (delay_next == '0)
                    begin
                        counter_next = reload_reg;
                        irq          = 1'b1;
                    end
                end
                // prescaler and counter advance
                if (enabled_reg)
                begin
                    if (pre_inc >= period_of(rate_reg))
                    begin
                        prescale_next = '0;
                        if (counter_next == COUNTER_MAX)
                        begin
                            counter_next = '0;
                            delay_next   = RELOAD_DELAY_TICKS;
                        end
                        else
                        begin
                            counter_next = counter_next + 8'd1;
                        end
                    end
                    else
                    begin
                        prescale_next = pre_inc[PRESCALE_W-1:0];
                    end
                end
            end
            OP_WR_COUNTER:
            begin
                counter_next = item.data;
                delay_next   = '0;
            end
            OP_WR_CONTROL:
            begin
                // only a write that enables a stopped timer counts
                if (!enabled_reg && item.data[CTRL_ENABLE_BIT])
                begin
                    enabled_next  = 1'b1;
                    rate_next     = item.data[1:0];
                    prescale_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= '0;
            counter_reg  <= '0;
            prescale_reg <= '0;
            enabled_reg  <= 1'b0;
            rate_reg     <= 2'd0;
            delay_reg    <= '0;
        end
        else
        begin
            if (reload_we)
            begin
                reload_reg <= reload_data;
            end
            if (fire)
            begin
                counter_reg  <= counter_next;
                prescale_reg <= prescale_next;
                enabled_reg  <= enabled_next;
                rate_reg     <= rate_next;
                delay_reg    <= delay_next;
            end
        end
    end

    assign result.counter_value   = counter_next;
    assign result.timer_interrupt = irq;
    assign status.enabled         = enabled_reg;
    assign status.reload_delay    = delay_reg;

endmodule

`default_nettype wire

// ----- sv/pstmr_out_stage.sv -----
// ----------------------------------------------------------------------------
// pstmr_out_stage
// Result register toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pstmr_out_stage
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,      // a result is produced
    input  wire pstmr_pkg::result_t        result,
    output logic                           can_load,  // register free this cycle
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,   // counter_value[7:0]
    output logic [0:0]                     m_tuser    // timer_interrupt
);

    import pstmr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign can_load = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = result_reg.counter_value;
    assign m_tuser[0] = result_reg.timer_interrupt;

endmodule

`default_nettype wire

// ----- sv/prescaled_timer_with_delayed_reload.sv -----
// ----------------------------------------------------------------------------
// prescaled_timer_with_delayed_reload
// 8-bit prescaled timer with delayed reload and interrupt pulse.
// ----------------------------------------------------------------------------
// Each input beat is a tick, a counter write or a control write (tuser), and
// each beat yields exactly one result beat with the counter after it and the
// interrupt flag. A beat passes through an input register, the state update
// in the core, and a result register. The state update is combinational, so
// throughput is one beat per clock while the output is ready. The reload
// value is written through reload_we/reload_data while idle: the user must
// keep to this, as the block does not enforce it.
`default_nettype none

module prescaled_timer_with_delayed_reload
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       reload_we,
    input  wire logic [7:0] reload_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // write_data[7:0]
    input  wire logic [1:0] s_tuser,   // operation[1:0]
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // counter_value[7:0]
    output logic [0:0]      m_tuser    // timer_interrupt
);

    import pstmr_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    status_t status;
    logic    can_load;
    logic    fire;

    // a held beat moves on when the result register is free
    assign fire = item_valid && can_load;

    pstmr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    pstmr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .reload_we   (reload_we),
        .reload_data (reload_data),
        .fire        (fire),
        .item        (item),
        .result      (result),
        .status      (status)
    );

    pstmr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // reload countdown never exceeds its start value
    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.reload_delay <= RELOAD_DELAY_TICKS)
        else $error("reload delay out of range");

    // once enabled the timer stays enabled
    a_enable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.enabled |=> status.enabled)
        else $error("timer was disabled");

    // a stalled output keeps the held input beat
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_tvalid && !m_tready) |=> item_valid)
        else $error("input beat dropped under stall");
`endif

endmodule

`default_nettype wire
